// ===== rtl/crf_pkg.sv =====
package crf_pkg;

	// Defaults for the top-level parameters
	localparam int MAX_PAYLOAD_DEF = 32;
	localparam int JOB_DEPTH_DEF   = 4;

	// Fixed field widths
	localparam int BYTE_W    = 8;
	localparam int FLEN_W    = 6;
	localparam int BIDX_W    = 5;
	localparam int CFG_IDX_W = 2;
	localparam int CRC_W     = 16;
	// Queued length field covers payload lengths up to 127
	localparam int JOB_LEN_W = 7;

	localparam logic [CRC_W-1:0] CRC_INIT = 16'hFFFF;
	localparam logic [CRC_W-1:0] CRC_POLY = 16'h1021;

	localparam logic [BYTE_W-1:0] HEAD_RST    = 8'hA6;
	localparam logic [BYTE_W-1:0] NODE_RST    = 8'h01;
	localparam logic [BYTE_W-1:0] TIMEOUT_RST = 8'd50;

	typedef enum logic [2:0] {
		PH_HEAD,
		PH_NODE,
		PH_CMD,
		PH_LEN,
		PH_DATA,
		PH_CRCL,
		PH_CRCH
	} parse_phase_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_FRAME_HEAD,
		REG_NODE_ID,
		REG_ONLINE_TIMEOUT
	} cfg_reg_t;

	typedef enum logic {
		BK_IDLE,
		BK_EMIT
	} back_state_t;

	// One entry of the queue between parser and emitter
	typedef struct packed {
		logic                  is_frame;
		logic                  online;
		logic [BYTE_W-1:0]     command;
		logic [JOB_LEN_W-1:0]  len;
	} job_t;

	// CRC-16, MSB first, one byte
	function automatic logic [CRC_W-1:0] crc_step(logic [CRC_W-1:0] crc,
		logic [BYTE_W-1:0] b);
		logic [CRC_W-1:0] c;
		c = crc ^ {b, 8'h00};
		for (int k = 0; k < 8; k++) begin
			if (c[CRC_W-1])
				c = {c[CRC_W-2:0], 1'b0} ^ CRC_POLY;
			else
				c = {c[CRC_W-2:0], 1'b0};
		end
		return c;
	endfunction

endpackage

// ===== rtl/crf_front.sv =====
module crf_front import crf_pkg::*; #(
	parameter int MAX_PAYLOAD = MAX_PAYLOAD_DEF,
	parameter int JOB_DEPTH   = JOB_DEPTH_DEF,
	localparam int AW = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1,
	localparam int FW = $clog2(MAX_PAYLOAD + 1)
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_valid,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [BYTE_W-1:0]    cfg_data,
	input  logic                 push,
	output logic                 full,
	input  logic                 action,
	input  logic [BYTE_W-1:0]    rx_byte,
	output logic                 job_push,
	output job_t                 job_data,
	input  logic                 job_full,
	input  logic                 frame_done,
	output logic                 mem_we,
	output logic [AW-1:0]        mem_waddr,
	output logic [BYTE_W-1:0]    mem_wdata
);

	localparam int PW = $clog2(JOB_DEPTH + 2);

	logic [BYTE_W-1:0] head_q, node_id_q, timeout_q;

	parse_phase_t      phase_q, phase_d;
	logic [BYTE_W-1:0] node_q, node_d;
	logic [BYTE_W-1:0] cmd_q, cmd_d;
	logic [FW-1:0]     len_q, len_d;
	logic [FW-1:0]     fill_q, fill_d;
	logic [CRC_W-1:0]  crc_q, crc_d;
	logic [BYTE_W-1:0] rlo_q, rlo_d;
	logic [BYTE_W-1:0] ticks_q, ticks_d;
	logic [PW-1:0]     pending_q;

	logic accept;
	logic good;
	logic inc_pending;

	// Stall on a full job queue, and stall all items in the payload phase while an earlier frame is still being read out
	assign full   = job_full || (phase_q == PH_DATA && pending_q != '0);
	assign accept = push && !full;

	assign mem_waddr = fill_q[AW-1:0];
	assign mem_wdata = rx_byte;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q    <= HEAD_RST;
			node_id_q <= NODE_RST;
			timeout_q <= TIMEOUT_RST;
		end else if (cfg_valid) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_FRAME_HEAD:     head_q    <= cfg_data;
				REG_NODE_ID:        node_id_q <= cfg_data;
				REG_ONLINE_TIMEOUT: timeout_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_HEAD;
			node_q    <= '0;
			cmd_q     <= '0;
			len_q     <= '0;
			fill_q    <= '0;
			crc_q     <= CRC_INIT;
			rlo_q     <= '0;
			ticks_q   <= '0;
			pending_q <= '0;
		end else begin
			phase_q   <= phase_d;
			node_q    <= node_d;
			cmd_q     <= cmd_d;
			len_q     <= len_d;
			fill_q    <= fill_d;
			crc_q     <= crc_d;
			rlo_q     <= rlo_d;
			ticks_q   <= ticks_d;
			pending_q <= pending_q + PW'(inc_pending) - PW'(frame_done);
		end
	end

	always_comb begin
		phase_d     = phase_q;
		node_d      = node_q;
		cmd_d       = cmd_q;
		len_d       = len_q;
		fill_d      = fill_q;
		crc_d       = crc_q;
		rlo_d       = rlo_q;
		ticks_d     = ticks_q;
		mem_we      = 1'b0;
		job_push    = 1'b0;
		job_data    = '0;
		good        = 1'b0;
		inc_pending = 1'b0;
		if (accept) begin
			job_push = 1'b1;
			if (action) begin
				if (ticks_q != '0)
					ticks_d = ticks_q - 8'd1;
			end else begin
				unique case (phase_q)
					PH_HEAD: begin
						if (rx_byte == head_q) begin
							crc_d   = CRC_INIT;
							phase_d = PH_NODE;
						end
					end
					PH_NODE: begin
						node_d  = rx_byte;
						crc_d   = crc_step(crc_q, rx_byte);
						phase_d = PH_CMD;
					end
					PH_CMD: begin
						cmd_d   = rx_byte;
						crc_d   = crc_step(crc_q, rx_byte);
						phase_d = PH_LEN;
					end
					PH_LEN: begin
						crc_d  = crc_step(crc_q, rx_byte);
						fill_d = '0;
						if (rx_byte > 8'(MAX_PAYLOAD)) begin
							phase_d = PH_HEAD;
						end else begin
							len_d   = rx_byte[FW-1:0];
							phase_d = (rx_byte == 8'd0) ? PH_CRCL : PH_DATA;
						end
					end
					PH_DATA: begin
						mem_we = 1'b1;
						crc_d  = crc_step(crc_q, rx_byte);
						fill_d = fill_q + 1'b1;
						if (fill_d >= len_q)
							phase_d = PH_CRCL;
					end
					PH_CRCL: begin
						rlo_d   = rx_byte;
						phase_d = PH_CRCH;
					end
					PH_CRCH: begin
						phase_d = PH_HEAD;
						if (node_q == node_id_q && {rx_byte, rlo_q} == crc_q) begin
							good    = 1'b1;
							ticks_d = timeout_q;
						end
					end
					default: phase_d = PH_HEAD;
				endcase
			end
			job_data.is_frame = good;
			job_data.online   = (ticks_d != '0);
			job_data.command  = good ? cmd_q : '0;
			job_data.len      = good ? JOB_LEN_W'(len_q) : '0;
			inc_pending       = good && (len_q != '0);
		end
	end

endmodule

// ===== rtl/crf_job_fifo.sv =====
module crf_job_fifo import crf_pkg::*; #(
	parameter int JOB_DEPTH = JOB_DEPTH_DEF,
	localparam int PTR_W = (JOB_DEPTH > 1) ? $clog2(JOB_DEPTH) : 1,
	localparam int CNT_W = $clog2(JOB_DEPTH + 1)
) (
	input  logic clk,
	input  logic arst_n,
	input  logic wr_en,
	input  job_t wr_data,
	output logic full,
	input  logic rd_en,
	output job_t rd_data,
	output logic empty
);

	job_t             slot_q [JOB_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_wr, do_rd;

	assign full    = (count_q == CNT_W'(JOB_DEPTH));
	assign empty   = (count_q == '0);
	assign do_wr   = wr_en && !full;
	assign do_rd   = rd_en && !empty;
	assign rd_data = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_wr)
			slot_q[wr_ptr_q] <= wr_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_wr)
				wr_ptr_q <= (wr_ptr_q == PTR_W'(JOB_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			if (do_rd)
				rd_ptr_q <= (rd_ptr_q == PTR_W'(JOB_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			count_q <= count_q + CNT_W'(do_wr) - CNT_W'(do_rd);
		end
	end

endmodule

// ===== rtl/crf_back.sv =====
module crf_back import crf_pkg::*; #(
	parameter int MAX_PAYLOAD = MAX_PAYLOAD_DEF,
	localparam int AW = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1,
	localparam int FW = $clog2(MAX_PAYLOAD + 1)
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              mem_we,
	input  logic [AW-1:0]     mem_waddr,
	input  logic [BYTE_W-1:0] mem_wdata,
	input  logic              job_empty,
	input  job_t              job_data,
	output logic              job_pop,
	output logic              frame_done,
	output logic              empty,
	input  logic              pop,
	output logic              result_kind,
	output logic              online,
	output logic [BYTE_W-1:0] command,
	output logic [FLEN_W-1:0] frame_length,
	output logic [BIDX_W-1:0] byte_index,
	output logic [BYTE_W-1:0] payload_byte,
	output logic              last
);

	logic [BYTE_W-1:0] mem [MAX_PAYLOAD];
	logic [BYTE_W-1:0] rd_data_q;
	logic              rd_en;
	logic [AW-1:0]     rd_addr;

	back_state_t       state_q, state_d;
	logic [AW-1:0]     idx_q, idx_d;
	logic [FW-1:0]     cur_len_q;
	logic [BYTE_W-1:0] cur_cmd_q;
	logic              cur_online_q;
	logic              latch_job;

	logic              out_valid_q;
	logic              out_free, load;
	logic              kind_d, online_d, last_d;
	logic [BYTE_W-1:0] cmd_d, byte_d;
	logic [FLEN_W-1:0] flen_d;
	logic [BIDX_W-1:0] bidx_d;
	logic              is_last;

	assign empty    = !out_valid_q;
	assign out_free = !out_valid_q || pop;
	assign is_last  = (FW'(idx_q) + 1'b1 == cur_len_q);

	always_ff @(posedge clk) begin
		if (mem_we)
			mem[mem_waddr] <= mem_wdata;
		if (rd_en)
			rd_data_q <= mem[rd_addr];
	end

	always_ff @(posedge clk) begin
		if (latch_job) begin
			cur_len_q    <= job_data.len[FW-1:0];
			cur_cmd_q    <= job_data.command;
			cur_online_q <= job_data.online;
		end
		if (load) begin
			result_kind  <= kind_d;
			online       <= online_d;
			command      <= cmd_d;
			frame_length <= flen_d;
			byte_index   <= bidx_d;
			payload_byte <= byte_d;
			last         <= last_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= BK_IDLE;
			idx_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			idx_q   <= idx_d;
			if (load)
				out_valid_q <= 1'b1;
			else if (pop)
				out_valid_q <= 1'b0;
		end
	end

	always_comb begin
		state_d    = state_q;
		idx_d      = idx_q;
		job_pop    = 1'b0;
		latch_job  = 1'b0;
		frame_done = 1'b0;
		rd_en      = 1'b0;
		rd_addr    = idx_q;
		load       = 1'b0;
		kind_d     = 1'b0;
		online_d   = 1'b0;
		cmd_d      = '0;
		flen_d     = '0;
		bidx_d     = '0;
		byte_d     = '0;
		last_d     = 1'b1;
		unique case (state_q)
			BK_IDLE: begin
				if (!job_empty) begin
					if (job_data.is_frame && job_data.len != '0) begin
						// start the read-out; first byte arrives next cycle
						job_pop   = 1'b1;
						latch_job = 1'b1;
						idx_d     = '0;
						rd_en     = 1'b1;
						rd_addr   = '0;
						state_d   = BK_EMIT;
					end else if (out_free) begin
						job_pop  = 1'b1;
						load     = 1'b1;
						kind_d   = job_data.is_frame;
						online_d = job_data.online;
						cmd_d    = job_data.command;
					end
				end
			end
			BK_EMIT: begin
				if (out_free) begin
					load     = 1'b1;
					kind_d   = 1'b1;
					online_d = cur_online_q;
					cmd_d    = cur_cmd_q;
					flen_d   = FLEN_W'(cur_len_q);
					bidx_d   = BIDX_W'(idx_q);
					byte_d   = rd_data_q;
					last_d   = is_last;
					if (is_last) begin
						frame_done = 1'b1;
						state_d    = BK_IDLE;
					end else begin
						idx_d   = idx_q + 1'b1;
						rd_en   = 1'b1;
						rd_addr = idx_q + 1'b1;
					end
				end
			end
			default: state_d = BK_IDLE;
		endcase
	end

endmodule

// ===== rtl/crc_frame_receiver_top.sv =====
// Framed packet receiver with CRC-16 (poly 0x1021, init 0xFFFF) check. Each
// input item is a received byte or a 10 ms tick; every item gives one status
// result, except the closing CRC byte of a good frame addressed to node_id,
// which gives one record per payload byte (or one empty record for length 0).
// The parser takes one item per cycle while full is low. full is high when the
// job queue is full, or while the parser is collecting payload and an earlier
// frame is still being read out of the single payload memory; ticks wait behind
// it as well. A status result goes through the job queue to the output register.
// The first record of a frame also goes through the memory read register. The
// remaining records follow at one per cycle while pop is held, limited by the
// one memory read port. Configuration writes are always taken (cfg_ready is
// tied high); index 3 is ignored.
module crc_frame_receiver_top import crf_pkg::*; #(
	parameter int MAX_PAYLOAD = MAX_PAYLOAD_DEF,
	parameter int JOB_DEPTH   = JOB_DEPTH_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [BYTE_W-1:0]    cfg_data,
	input  logic                 push,
	output logic                 full,
	input  logic                 action,
	input  logic [BYTE_W-1:0]    rx_byte,
	output logic                 empty,
	input  logic                 pop,
	output logic                 result_kind,
	output logic                 online,
	output logic [BYTE_W-1:0]    command,
	output logic [FLEN_W-1:0]    frame_length,
	output logic [BIDX_W-1:0]    byte_index,
	output logic [BYTE_W-1:0]    payload_byte,
	output logic                 last
);

	localparam int AW = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;

	logic              job_push, job_full, job_pop, job_empty;
	job_t              job_in, job_out;
	logic              frame_done;
	logic              mem_we;
	logic [AW-1:0]     mem_waddr;
	logic [BYTE_W-1:0] mem_wdata;

	assign cfg_ready = 1'b1;

	crf_front #(
		.MAX_PAYLOAD(MAX_PAYLOAD),
		.JOB_DEPTH  (JOB_DEPTH)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.push      (push),
		.full      (full),
		.action    (action),
		.rx_byte   (rx_byte),
		.job_push  (job_push),
		.job_data  (job_in),
		.job_full  (job_full),
		.frame_done(frame_done),
		.mem_we    (mem_we),
		.mem_waddr (mem_waddr),
		.mem_wdata (mem_wdata)
	);

	crf_job_fifo #(
		.JOB_DEPTH(JOB_DEPTH)
	) u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.wr_en  (job_push),
		.wr_data(job_in),
		.full   (job_full),
		.rd_en  (job_pop),
		.rd_data(job_out),
		.empty  (job_empty)
	);

	crf_back #(
		.MAX_PAYLOAD(MAX_PAYLOAD)
	) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.mem_we      (mem_we),
		.mem_waddr   (mem_waddr),
		.mem_wdata   (mem_wdata),
		.job_empty   (job_empty),
		.job_data    (job_out),
		.job_pop     (job_pop),
		.frame_done  (frame_done),
		.empty       (empty),
		.pop         (pop),
		.result_kind (result_kind),
		.online      (online),
		.command     (command),
		.frame_length(frame_length),
		.byte_index  (byte_index),
		.payload_byte(payload_byte),
		.last        (last)
	);

endmodule

// ===== test/tb_top.sv =====
module tb_top;
	import crf_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int CYCLE_LIMIT = 300000;
	// Index 3 maps to no register and must be ignored
	localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;

	typedef struct packed {
		logic              kind;
		logic              online;
		logic [BYTE_W-1:0] cmd;
		logic [FLEN_W-1:0] flen;
		logic [BIDX_W-1:0] idx;
		logic [BYTE_W-1:0] data;
		logic              last;
	} frame_rec_t;

	class frame_tracker;
		logic [BYTE_W-1:0] head_byte;
		logic [BYTE_W-1:0] node_addr;
		logic [BYTE_W-1:0] reload_ticks;
		parse_phase_t      phase;
		logic [BYTE_W-1:0] f_node;
		logic [BYTE_W-1:0] f_cmd;
		logic [FLEN_W-1:0] f_len;
		logic [FLEN_W-1:0] fill;
		logic [BYTE_W-1:0] store [MAX_PAYLOAD_DEF];
		logic [CRC_W-1:0]  crc_run;
		logic [CRC_W-1:0]  crc_rx;
		logic [BYTE_W-1:0] ticks_left;
		frame_rec_t        due_records [$];
		int n_items, n_records, n_frames, n_writes, n_fail;

		function new();
			head_byte = HEAD_RST;
			node_addr = NODE_RST;
			reload_ticks = TIMEOUT_RST;
			phase = PH_HEAD;
			f_node = '0;
			f_cmd = '0;
			f_len = '0;
			fill = '0;
			foreach (store[i]) store[i] = '0;
			crc_run = CRC_INIT;
			crc_rx = '0;
			ticks_left = '0;
			n_items = 0;
			n_records = 0;
			n_frames = 0;
			n_writes = 0;
			n_fail = 0;
		endfunction

		// Bit-serial form, MSB first
		static function logic [CRC_W-1:0] crc16_byte(logic [CRC_W-1:0] c,
			logic [BYTE_W-1:0] d);
			logic fb;
			for (int i = BYTE_W - 1; i >= 0; i--) begin
				fb = c[CRC_W-1] ^ d[i];
				c = {c[CRC_W-2:0], 1'b0};
				if (fb)
					c = c ^ CRC_POLY;
			end
			return c;
		endfunction

		function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [BYTE_W-1:0] val);
			n_writes++;
			unique case (idx)
			REG_FRAME_HEAD:     head_byte = val;
			REG_NODE_ID:        node_addr = val;
			REG_ONLINE_TIMEOUT: reload_ticks = val;
			default:            ;
			endcase
		endfunction

		function void add_record(logic kind, int idx, logic [BYTE_W-1:0] data, logic last);
			frame_rec_t r;
			r.kind = kind;
			r.online = (ticks_left != 0);
			r.cmd = kind ? f_cmd : '0;
			r.flen = kind ? f_len : '0;
			r.idx = idx[BIDX_W-1:0];
			r.data = data;
			r.last = last;
			due_records.push_back(r);
		endfunction

		function void take_item(logic act, logic [BYTE_W-1:0] b);
			n_items++;
			if (act) begin
				if (ticks_left != 0)
					ticks_left--;
				add_record(1'b0, 0, '0, 1'b1);
				return;
			end
			unique case (phase)
			PH_HEAD: begin
				if (b == head_byte) begin
					crc_run = CRC_INIT;
					phase = PH_NODE;
				end
			end
			PH_NODE: begin
				f_node = b;
				crc_run = crc16_byte(crc_run, b);
				phase = PH_CMD;
			end
			PH_CMD: begin
				f_cmd = b;
				crc_run = crc16_byte(crc_run, b);
				phase = PH_LEN;
			end
			PH_LEN: begin
				crc_run = crc16_byte(crc_run, b);
				fill = '0;
				// oversized length: drop the frame and hunt for the head again
				if (b > MAX_PAYLOAD_DEF) begin
					phase = PH_HEAD;
				end else begin
					f_len = b[FLEN_W-1:0];
					phase = (b == 0) ? PH_CRCL : PH_DATA;
				end
			end
			PH_DATA: begin
				store[fill] = b;
				crc_run = crc16_byte(crc_run, b);
				fill++;
				if (fill >= f_len)
					phase = PH_CRCL;
			end
			PH_CRCL: begin
				crc_rx = {8'h00, b};
				phase = PH_CRCH;
			end
			PH_CRCH: begin
				crc_rx[15:8] = b;
				phase = PH_HEAD;
				if (f_node == node_addr && crc_rx == crc_run) begin
					ticks_left = reload_ticks;
					n_frames++;
					if (f_len == 0) begin
						add_record(1'b1, 0, '0, 1'b1);
					end else begin
						for (int i = 0; i < f_len; i++)
							add_record(1'b1, i, store[i], i == f_len - 1);
					end
					return;
				end
			end
			default: phase = PH_HEAD;
			endcase
			add_record(1'b0, 0, '0, 1'b1);
		endfunction

		task report(string msg);
			n_fail++;
			if (n_fail <= 50)
				$display("mismatch: %s", msg);
		endtask

		task cmp_field(string name, logic [15:0] got, logic [15:0] want);
			if (got !== want)
				report($sformatf("record %0d %s: got %0h, want %0h", n_records, name,
					got, want));
		endtask

		task check_record(frame_rec_t got);
			frame_rec_t want;
			n_records++;
			if (due_records.size() == 0) begin
				report($sformatf("record %0d arrived with nothing outstanding", n_records));
				return;
			end
			want = due_records.pop_front();
			cmp_field("result_kind", got.kind, want.kind);
			cmp_field("online", got.online, want.online);
			cmp_field("command", got.cmd, want.cmd);
			cmp_field("frame_length", got.flen, want.flen);
			cmp_field("byte_index", got.idx, want.idx);
			cmp_field("payload_byte", got.data, want.data);
			cmp_field("last", got.last, want.last);
		endtask
	endclass

	logic                 clk;
	logic                 arst_n;
	logic                 cfg_valid;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [BYTE_W-1:0]    cfg_data;
	logic                 push;
	logic                 full;
	logic                 action;
	logic [BYTE_W-1:0]    rx_byte;
	logic                 empty;
	logic                 pop;
	logic                 result_kind;
	logic                 online;
	logic [BYTE_W-1:0]    command;
	logic [FLEN_W-1:0]    frame_length;
	logic [BIDX_W-1:0]    byte_index;
	logic [BYTE_W-1:0]    payload_byte;
	logic                 last;

	frame_tracker sb = new();
	int cycle_count = 0;
	int burst_left = 0;

	crc_frame_receiver_top u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.push(push),
		.full(full),
		.action(action),
		.rx_byte(rx_byte),
		.empty(empty),
		.pop(pop),
		.result_kind(result_kind),
		.online(online),
		.command(command),
		.frame_length(frame_length),
		.byte_index(byte_index),
		.payload_byte(payload_byte),
		.last(last)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("status: fail");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (arst_n && pop && !empty)
			sb.check_record({result_kind, online, command, frame_length, byte_index,
				payload_byte, last});
	end

	// Receiver: free-flowing, random and long-hold stretches in turn
	initial begin
		int hold;
		hold = 0;
		pop = 1'b0;
		wait (arst_n);
		forever begin
			@(negedge clk);
			if (hold > 0) begin
				hold--;
				pop <= 1'b0;
			end else begin
				unique case ((cycle_count >> 7) % 3)
				0: pop <= 1'b1;
				1: pop <= ($urandom_range(0, 2) != 0);
				default: begin
					if ($urandom_range(0, 7) == 0) begin
						hold = $urandom_range(3, 19);
						pop <= 1'b0;
					end else begin
						pop <= 1'b1;
					end
				end
				endcase
			end
		end
	end

	task automatic send_item(input logic act, input logic [BYTE_W-1:0] b);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 12);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
			if (gap > 0) begin
				@(negedge clk);
				push <= 1'b0;
				repeat (gap - 1) @(negedge clk);
			end
		end
		@(negedge clk);
		push <= 1'b1;
		action <= act;
		rx_byte <= b;
		do @(posedge clk); while (full);
		sb.take_item(act, b);
		burst_left--;
	endtask

	task automatic send_frame(input logic [BYTE_W-1:0] node, input logic [BYTE_W-1:0] cmd,
		input int len, input bit spoil);
		logic [CRC_W-1:0]  crc;
		logic [BYTE_W-1:0] body [$];
		body.push_back(node);
		body.push_back(cmd);
		body.push_back(8'(len));
		repeat (len) body.push_back(8'($urandom_range(0, 255)));
		crc = CRC_INIT;
		foreach (body[i]) crc = frame_tracker::crc16_byte(crc, body[i]);
		if (spoil)
			crc = crc ^ (16'h1 << $urandom_range(0, 15));
		send_item(1'b0, sb.head_byte);
		foreach (body[i]) send_item(1'b0, body[i]);
		send_item(1'b0, crc[7:0]);
		send_item(1'b0, crc[15:8]);
	endtask

	task automatic send_oversize(input logic [BYTE_W-1:0] len_byte);
		send_item(1'b0, sb.head_byte);
		send_item(1'b0, sb.node_addr);
		send_item(1'b0, 8'($urandom_range(0, 255)));
		send_item(1'b0, len_byte);
	endtask

	// Mostly well-formed frames; the rest ticks, noise and broken frames
	task automatic run_traffic(input int stop_at);
		int pick;
		int r;
		int len;
		logic [BYTE_W-1:0] node;
		while (sb.n_items < stop_at) begin
			pick = $urandom_range(0, 99);
			if (pick < 60) begin
				node = ($urandom_range(0, 6) == 0) ? 8'($urandom_range(0, 255)) : sb.node_addr;
				r = $urandom_range(0, 19);
				len = (r < 14) ? $urandom_range(0, 4) :
					(r < 19) ? $urandom_range(5, 12) : $urandom_range(28, MAX_PAYLOAD_DEF);
				send_frame(node, 8'($urandom_range(0, 255)), len, $urandom_range(0, 6) == 0);
			end else if (pick < 72) begin
				repeat ($urandom_range(1, 4)) send_item(1'b1, 8'($urandom_range(0, 255)));
			end else if (pick < 82) begin
				repeat ($urandom_range(1, 3)) send_item(1'b0, 8'($urandom_range(0, 255)));
			end else if (pick < 91) begin
				send_oversize(8'($urandom_range(MAX_PAYLOAD_DEF + 1, 255)));
			end else begin
				// truncated frame: leave the parser mid-frame
				send_item(1'b0, sb.head_byte);
				repeat ($urandom_range(1, 4)) send_item(1'b0, 8'($urandom_range(0, 255)));
			end
		end
	endtask

	task automatic settle();
		@(negedge clk);
		push <= 1'b0;
		burst_left = 0;
		while (sb.due_records.size() != 0) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [BYTE_W-1:0] val);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		sb.set_reg(idx, val);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	initial begin
		push = 1'b0;
		action = 1'b0;
		rx_byte = '0;
		cfg_valid = 1'b0;
		cfg_index = REG_FRAME_HEAD;
		cfg_data = '0;
		arst_n = 1'b0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Defaults: tick at zero, extreme bytes, empty frame, oversized lengths, frame for another node
		send_item(1'b1, 8'hFF);
		send_item(1'b0, 8'h00);
		send_item(1'b0, 8'hFF);
		send_frame(NODE_RST, 8'hFF, 0, 1'b0);
		send_item(1'b1, 8'h00);
		send_oversize(8'(MAX_PAYLOAD_DEF + 1));
		send_oversize(8'hFF);
		send_frame(8'h02, 8'h10, 1, 1'b0);
		settle();

		write_reg(REG_FRAME_HEAD, 8'h00);
		write_reg(REG_NODE_ID, 8'hFF);
		write_reg(REG_ONLINE_TIMEOUT, 8'd1);
		send_frame(sb.node_addr, 8'h3C, MAX_PAYLOAD_DEF, 1'b0);
		run_traffic(80);
		settle();

		write_reg(REG_FRAME_HEAD, 8'hFF);
		write_reg(REG_NODE_ID, 8'h00);
		write_reg(REG_ONLINE_TIMEOUT, 8'hFF);
		write_reg(REG_SPARE, 8'($urandom_range(0, 255)));
		run_traffic(125);
		settle();

		// zero timeout: good frames leave the link offline
		write_reg(REG_FRAME_HEAD, 8'($urandom_range(0, 255)));
		write_reg(REG_NODE_ID, 8'($urandom_range(0, 255)));
		write_reg(REG_ONLINE_TIMEOUT, 8'd0);
		run_traffic(165);
		settle();

		write_reg(REG_FRAME_HEAD, 8'($urandom_range(0, 255)));
		write_reg(REG_NODE_ID, 8'($urandom_range(0, 255)));
		write_reg(REG_ONLINE_TIMEOUT, 8'($urandom_range(2, 12)));
		run_traffic(205);
		settle();
		repeat (8) @(posedge clk);

		$display("covered %0d items, %0d good frames, %0d records, %0d register writes",
			sb.n_items, sb.n_frames, sb.n_records, sb.n_writes);
		$display("settings went from reset values to extreme heads, nodes and timeouts");
		if (sb.n_fail == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule

// ===== files.f =====
rtl/crf_pkg.sv
rtl/crf_front.sv
rtl/crf_job_fifo.sv
rtl/crf_back.sv
rtl/crc_frame_receiver_top.sv
test/tb_top.sv
